/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/dcsio_pkg.sv */
// shared types and constants of the dual cpu shared i/o register block
// no dependencies
`default_nettype none

package dcsio_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned DataW = 8;
  localparam int unsigned KeyW  = 10;
  localparam int unsigned ExtW  = 7;

  // register addresses
  localparam logic [AddrW-1:0] AddrKeyinLo  = 32'h0400_0130;
  localparam logic [AddrW-1:0] AddrKeyinHi  = 32'h0400_0131;
  localparam logic [AddrW-1:0] AddrKeyctlLo = 32'h0400_0132;
  localparam logic [AddrW-1:0] AddrKeyctlHi = 32'h0400_0133;
  localparam logic [AddrW-1:0] AddrExtkeyLo = 32'h0400_0136;
  localparam logic [AddrW-1:0] AddrExtkeyHi = 32'h0400_0137;
  localparam logic [AddrW-1:0] AddrMemLo    = 32'h0400_0204;
  localparam logic [AddrW-1:0] AddrMemHi    = 32'h0400_0205;
  localparam logic [AddrW-1:0] AddrWmapMain = 32'h0400_0247;
  localparam logic [AddrW-1:0] AddrWmapSec  = 32'h0400_0241;

  // field masks
  localparam logic [7:0]  KeyctlHiMask  = 8'hC3;
  localparam logic [7:0]  MemctlHiMask  = 8'hC8;
  localparam logic [7:0]  MemctlHiForce = 8'h20;
  localparam logic [15:0] MirrorMask    = 16'hFF80;
  localparam logic [15:0] StatusLoMask  = 16'h007F;
  localparam logic [1:0]  WmapMask      = 2'b11;
  localparam logic [1:0]  WmapReset     = 2'b11;

  // access kinds
  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;
  localparam logic CpuMain   = 1'b0;
  localparam logic CpuSecond = 1'b1;

  typedef struct packed {
    logic             mode;
    logic             cpu;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic [KeyW-1:0]  key_lines;
    logic [ExtW-1:0]  ext_key_lines;
  } access_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             unknown_address;
    logic             wram_refresh;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/dcsio_regs.sv */
// register file with address decode, read mux and masked write update
// depends on dcsio_pkg
`default_nettype none

module dcsio_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              commit_i,
  input  wire dcsio_pkg::access_t acc_i,
  output dcsio_pkg::result_t     res_o
);

  logic [15:0] key_ctrl_main_q, key_ctrl_main_d;
  logic [15:0] key_ctrl_second_q, key_ctrl_second_d;
  logic [15:0] mem_ctrl_q, mem_ctrl_d;
  logic [15:0] mem_status_q, mem_status_d;
  logic [1:0]  wram_map_q, wram_map_d;

  logic        is_sec;
  logic [15:0] kc;
  logic [7:0]  wd;

  assign is_sec = (acc_i.cpu == dcsio_pkg::CpuSecond);
  assign kc     = is_sec ? key_ctrl_second_q : key_ctrl_main_q;
  assign wd     = acc_i.write_data;

  always_comb begin
    res_o             = '0;
    key_ctrl_main_d   = key_ctrl_main_q;
    key_ctrl_second_d = key_ctrl_second_q;
    mem_ctrl_d        = mem_ctrl_q;
    mem_status_d      = mem_status_q;
    wram_map_d        = wram_map_q;

    if (acc_i.mode == dcsio_pkg::ModeRead) begin
      if (acc_i.address == dcsio_pkg::AddrKeyinLo) begin
        res_o.read_data = acc_i.key_lines[7:0];
      end else if (acc_i.address == dcsio_pkg::AddrKeyinHi) begin
        res_o.read_data = {6'd0, acc_i.key_lines[9:8]};
      end else if (acc_i.address == dcsio_pkg::AddrKeyctlLo) begin
        res_o.read_data = kc[7:0];
      end else if (acc_i.address == dcsio_pkg::AddrKeyctlHi) begin
        res_o.read_data = kc[15:8];
      end else if (!is_sec && acc_i.address == dcsio_pkg::AddrMemLo) begin
        res_o.read_data = mem_ctrl_q[7:0];
      end else if (!is_sec && acc_i.address == dcsio_pkg::AddrMemHi) begin
        res_o.read_data = mem_ctrl_q[15:8];
      end else if (!is_sec && acc_i.address == dcsio_pkg::AddrWmapMain) begin
        res_o.read_data = {6'd0, wram_map_q};
      end else if (is_sec && acc_i.address == dcsio_pkg::AddrExtkeyLo) begin
        res_o.read_data = {1'b0, acc_i.ext_key_lines};
      end else if (is_sec && acc_i.address == dcsio_pkg::AddrExtkeyHi) begin
        res_o.read_data = '0;
      end else if (is_sec && acc_i.address == dcsio_pkg::AddrMemLo) begin
        res_o.read_data = mem_status_q[7:0];
      end else if (is_sec && acc_i.address == dcsio_pkg::AddrMemHi) begin
        res_o.read_data = mem_status_q[15:8];
      end else if (is_sec && acc_i.address == dcsio_pkg::AddrWmapSec) begin
        res_o.read_data = {6'd0, wram_map_q};
      end else begin
        res_o.unknown_address = 1'b1;
      end
    end else if (!is_sec) begin
      if (acc_i.address == dcsio_pkg::AddrKeyctlLo) begin
        key_ctrl_main_d = {key_ctrl_main_q[15:8], wd};
      end else if (acc_i.address == dcsio_pkg::AddrKeyctlHi) begin
        key_ctrl_main_d = {wd & dcsio_pkg::KeyctlHiMask, key_ctrl_main_q[7:0]};
      end else if (acc_i.address == dcsio_pkg::AddrMemLo) begin
        mem_ctrl_d   = {mem_ctrl_q[15:8], wd};
        mem_status_d = (mem_status_q & dcsio_pkg::StatusLoMask)
                     | (mem_ctrl_d & dcsio_pkg::MirrorMask);
      end else if (acc_i.address == dcsio_pkg::AddrMemHi) begin
        mem_ctrl_d   = {(wd & dcsio_pkg::MemctlHiMask) | dcsio_pkg::MemctlHiForce,
                        mem_ctrl_q[7:0]};
        mem_status_d = (mem_status_q & dcsio_pkg::StatusLoMask)
                     | (mem_ctrl_d & dcsio_pkg::MirrorMask);
      end else if (acc_i.address == dcsio_pkg::AddrWmapMain) begin
        wram_map_d         = wd[1:0] & dcsio_pkg::WmapMask;
        res_o.wram_refresh = 1'b1;
      end else begin
        res_o.unknown_address = 1'b1;
      end
    end else begin
      if (acc_i.address == dcsio_pkg::AddrKeyctlLo) begin
        key_ctrl_second_d = {key_ctrl_second_q[15:8], wd};
      end else if (acc_i.address == dcsio_pkg::AddrKeyctlHi) begin
        key_ctrl_second_d = {wd & dcsio_pkg::KeyctlHiMask, key_ctrl_second_q[7:0]};
      end else if (acc_i.address == dcsio_pkg::AddrMemLo) begin
        mem_status_d = (mem_ctrl_q & dcsio_pkg::MirrorMask)
                     | ({8'd0, wd} & dcsio_pkg::StatusLoMask);
      end else if (acc_i.address == dcsio_pkg::AddrMemHi) begin
        // accepted, nothing changes
      end else begin
        res_o.unknown_address = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_ctrl_main_q   <= '0;
      key_ctrl_second_q <= '0;
      mem_ctrl_q        <= '0;
      mem_status_q      <= '0;
      wram_map_q        <= dcsio_pkg::WmapReset;
    end else if (commit_i) begin
      key_ctrl_main_q   <= key_ctrl_main_d;
      key_ctrl_second_q <= key_ctrl_second_d;
      mem_ctrl_q        <= mem_ctrl_d;
      mem_status_q      <= mem_status_d;
      wram_map_q        <= wram_map_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dual_cpu_shared_io_registers.sv */
// top level of the dual cpu shared i/o register block
// depends on dcsio_pkg and dcsio_regs
`default_nettype none

// Byte-wide i/o register block shared by a main and a secondary processor.
// Each input transaction is one byte read or write from either port at a
// full 32-bit address; each produces exactly one output transaction carrying
// the read byte (0 on writes and unknown addresses), an unknown-address flag
// and a work-RAM refresh pulse. Internally a transaction lands in an input
// register, is decoded and applied to the register file by one short layer of
// compare/mux logic, and the answer is held in an output register, from which
// it can be taken. One transaction is taken every cycle as long as the output
// side keeps draining; the register file is written when a transaction moves
// from the input register to the output register, so each access sees every
// earlier one. Key lines are sampled with the transaction. Reset clears all
// control words and sets the work-RAM mapping field to 3.

module dual_cpu_shared_io_registers (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic        cpu_i,
  input  wire logic [31:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [9:0]  key_lines_i,
  input  wire logic [6:0]  ext_key_lines_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             unknown_address_o,
  output logic             wram_refresh_o
);

  // input register stage
  logic               s1_valid_q;
  dcsio_pkg::access_t s1_acc_q;

  // output register stage
  logic               out_valid_q;
  dcsio_pkg::result_t out_res_q;

  dcsio_pkg::result_t res;
  logic               s1_advance;

  // stage 1 moves on when the output register is empty or being drained
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  // take a new transaction whenever stage 1 is empty or moving on
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_acc_q.mode          <= mode_i;
      s1_acc_q.cpu           <= cpu_i;
      s1_acc_q.address       <= address_i;
      s1_acc_q.write_data    <= write_data_i;
      s1_acc_q.key_lines     <= key_lines_i;
      s1_acc_q.ext_key_lines <= ext_key_lines_i;
    end
  end

  // decode, read mux and register file update
  dcsio_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (s1_advance),
    .acc_i    (s1_acc_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_res_q.read_data;
  assign unknown_address_o = out_res_q.unknown_address;
  assign wram_refresh_o    = out_res_q.wram_refresh;

endmodule

`default_nettype wire

/* rtl/core/dcsio_checker.sv */
// port-level checker for the dual cpu shared i/o register block, bound to the top
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module dcsio_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        mode_i,
  input wire logic        cpu_i,
  input wire logic [31:0] address_i,
  input wire logic [7:0]  write_data_i,
  input wire logic [9:0]  key_lines_i,
  input wire logic [6:0]  ext_key_lines_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  read_data_o,
  input wire logic        unknown_address_o,
  input wire logic        wram_refresh_o
);

  // a held result keeps its value
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(read_data_o) && $stable(unknown_address_o)
               && $stable(wram_refresh_o))

  // input side only stalls when a result is waiting and blocked
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // an unknown access never returns data
  `ASSERT_IMPLIES(a_unknown_zero, clk_i, rst_ni, out_valid_o && unknown_address_o,
                  read_data_o == 8'd0)

  // a refresh comes from a good write, which returns no data
  `ASSERT_IMPLIES(a_refresh_write, clk_i, rst_ni, out_valid_o && wram_refresh_o,
                  !unknown_address_o && read_data_o == 8'd0)

endmodule

bind dual_cpu_shared_io_registers dcsio_checker u_dcsio_checker (.*);

`default_nettype wire

/* tb/tb_dual_cpu_shared_io_registers.sv */
// self-checking testbench for the dual cpu shared i/o register block
// depends on dcsio_pkg and dual_cpu_shared_io_registers
`timescale 1ns / 100ps

module tb_dual_cpu_shared_io_registers;

  localparam int unsigned MaxWait     = 13;
  localparam int unsigned RandomCount = 1100;
  localparam int unsigned DrainCycles = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic        cpu;
  logic [31:0] address;
  logic [7:0]  write_data;
  logic [9:0]  key_lines;
  logic [6:0]  ext_key_lines;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic        unknown_address;
  logic        wram_refresh;

  dual_cpu_shared_io_registers i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .mode_i            (mode),
    .cpu_i             (cpu),
    .address_i         (address),
    .write_data_i      (write_data),
    .key_lines_i       (key_lines),
    .ext_key_lines_i   (ext_key_lines),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .read_data_o       (read_data),
    .unknown_address_o (unknown_address),
    .wram_refresh_o    (wram_refresh)
  );

  // shadow copy of the register file, updated in acceptance order
  logic [15:0] sh_key_ctrl_main;
  logic [15:0] sh_key_ctrl_second;
  logic [15:0] sh_mem_ctrl;
  logic [15:0] sh_mem_status;
  logic [1:0]  sh_wram_map;

  // replies still owed by the block, oldest first
  dcsio_pkg::result_t awaited_replies[$];
  int unsigned        error_count = 0;

  // idle pattern state of each side: runs of busy or quiet transactions
  int unsigned tx_run_left = 0;
  bit          tx_quiet    = 1'b0;
  int unsigned rx_run_left = 0;
  bit          rx_quiet    = 1'b0;
  // long receiver hold-off requested by the back-pressure test
  int unsigned rx_hold_cycles = 0;

  // all registered addresses, used to aim most random traffic at real registers
  logic [31:0] reg_addrs[10] = '{
    dcsio_pkg::AddrKeyinLo, dcsio_pkg::AddrKeyinHi, dcsio_pkg::AddrKeyctlLo,
    dcsio_pkg::AddrKeyctlHi, dcsio_pkg::AddrExtkeyLo, dcsio_pkg::AddrExtkeyHi,
    dcsio_pkg::AddrMemLo, dcsio_pkg::AddrMemHi, dcsio_pkg::AddrWmapMain,
    dcsio_pkg::AddrWmapSec
  };

  // clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // wait length for one transaction: random up to MaxWait in busy runs, no wait in quiet runs
  function automatic int unsigned pick_wait(inout int unsigned run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 60);
      quiet    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // shadow register update and the reply one access must produce
  function automatic dcsio_pkg::result_t decode_access(dcsio_pkg::access_t acc);
    dcsio_pkg::result_t rep;
    logic [15:0]        kc;
    logic               sec;
    rep = '0;
    sec = (acc.cpu == dcsio_pkg::CpuSecond);
    kc  = sec ? sh_key_ctrl_second : sh_key_ctrl_main;
    if (acc.mode == dcsio_pkg::ModeRead) begin
      if (acc.address == dcsio_pkg::AddrKeyinLo) begin
        rep.read_data = acc.key_lines[7:0];
      end else if (acc.address == dcsio_pkg::AddrKeyinHi) begin
        rep.read_data = {6'b0, acc.key_lines[9:8]};
      end else if (acc.address == dcsio_pkg::AddrKeyctlLo) begin
        rep.read_data = kc[7:0];
      end else if (acc.address == dcsio_pkg::AddrKeyctlHi) begin
        rep.read_data = kc[15:8];
      end else if (!sec && acc.address == dcsio_pkg::AddrMemLo) begin
        rep.read_data = sh_mem_ctrl[7:0];
      end else if (!sec && acc.address == dcsio_pkg::AddrMemHi) begin
        rep.read_data = sh_mem_ctrl[15:8];
      end else if (!sec && acc.address == dcsio_pkg::AddrWmapMain) begin
        rep.read_data = {6'b0, sh_wram_map};
      end else if (sec && acc.address == dcsio_pkg::AddrExtkeyLo) begin
        rep.read_data = {1'b0, acc.ext_key_lines};
      end else if (sec && acc.address == dcsio_pkg::AddrExtkeyHi) begin
        rep.read_data = 8'h00;
      end else if (sec && acc.address == dcsio_pkg::AddrMemLo) begin
        rep.read_data = sh_mem_status[7:0];
      end else if (sec && acc.address == dcsio_pkg::AddrMemHi) begin
        rep.read_data = sh_mem_status[15:8];
      end else if (sec && acc.address == dcsio_pkg::AddrWmapSec) begin
        rep.read_data = {6'b0, sh_wram_map};
      end else begin
        rep.unknown_address = 1'b1;
      end
    end else if (!sec) begin
      if (acc.address == dcsio_pkg::AddrKeyctlLo) begin
        sh_key_ctrl_main[7:0] = acc.write_data;
      end else if (acc.address == dcsio_pkg::AddrKeyctlHi) begin
        sh_key_ctrl_main[15:8] = acc.write_data & dcsio_pkg::KeyctlHiMask;
      end else if (acc.address == dcsio_pkg::AddrMemLo) begin
        sh_mem_ctrl[7:0] = acc.write_data;
        sh_mem_status = (sh_mem_status & dcsio_pkg::StatusLoMask)
                      | (sh_mem_ctrl & dcsio_pkg::MirrorMask);
      end else if (acc.address == dcsio_pkg::AddrMemHi) begin
        // the fixed bit is set on every high-byte write
        sh_mem_ctrl[15:8] = (acc.write_data & dcsio_pkg::MemctlHiMask)
                          | dcsio_pkg::MemctlHiForce;
        sh_mem_status = (sh_mem_status & dcsio_pkg::StatusLoMask)
                      | (sh_mem_ctrl & dcsio_pkg::MirrorMask);
      end else if (acc.address == dcsio_pkg::AddrWmapMain) begin
        sh_wram_map      = acc.write_data[1:0] & dcsio_pkg::WmapMask;
        rep.wram_refresh = 1'b1;
      end else begin
        rep.unknown_address = 1'b1;
      end
    end else begin
      if (acc.address == dcsio_pkg::AddrKeyctlLo) begin
        sh_key_ctrl_second[7:0] = acc.write_data;
      end else if (acc.address == dcsio_pkg::AddrKeyctlHi) begin
        sh_key_ctrl_second[15:8] = acc.write_data & dcsio_pkg::KeyctlHiMask;
      end else if (acc.address == dcsio_pkg::AddrMemLo) begin
        // secondary side owns only the low status bits
        sh_mem_status = (sh_mem_ctrl & dcsio_pkg::MirrorMask)
                      | ({8'h00, acc.write_data} & dcsio_pkg::StatusLoMask);
      end else if (acc.address != dcsio_pkg::AddrMemHi) begin
        // high byte write is accepted and ignored, all else is unknown
        rep.unknown_address = 1'b1;
      end
    end
    return rep;
  endfunction

  function automatic dcsio_pkg::access_t make_access(logic m, logic c, logic [31:0] a,
                                                     logic [7:0] d, logic [9:0] k,
                                                     logic [6:0] e);
    dcsio_pkg::access_t acc;
    acc.mode          = m;
    acc.cpu           = c;
    acc.address       = a;
    acc.write_data    = d;
    acc.key_lines     = k;
    acc.ext_key_lines = e;
    return acc;
  endfunction

  // offer one transaction and record its reply once it is taken;
  // valid is only lowered by the next call, so back-to-back items keep it high
  task automatic send_access(input dcsio_pkg::access_t acc);
    int unsigned gap;
    gap = pick_wait(tx_run_left, tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= acc.mode;
    cpu           <= acc.cpu;
    address       <= acc.address;
    write_data    <= acc.write_data;
    key_lines     <= acc.key_lines;
    ext_key_lines <= acc.ext_key_lines;
    do @(posedge clk); while (!in_ready);
    awaited_replies.push_back(decode_access(acc));
  endtask

  // reply side: random stalls, checks each accepted reply against the oldest one owed
  initial begin
    int unsigned        stall;
    dcsio_pkg::result_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = pick_wait(rx_run_left, rx_quiet);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none owed, read_data %h unknown %b refresh %b",
                 $time, read_data, unknown_address, wram_refresh);
        error_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
          error_count++;
        end
        if (unknown_address !== want.unknown_address) begin
          $display("%0t: unknown_address expected %b actual %b",
                   $time, want.unknown_address, unknown_address);
          error_count++;
        end
        if (wram_refresh !== want.wram_refresh) begin
          $display("%0t: wram_refresh expected %b actual %b",
                   $time, want.wram_refresh, wram_refresh);
          error_count++;
        end
      end
    end
  end

  // live key lines: full-width extremes, high byte only has two bits
  task automatic test_key_inputs();
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, dcsio_pkg::AddrKeyinLo,
                            8'h00, 10'h3FF, 7'h7F));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, dcsio_pkg::AddrKeyinHi,
                            8'h00, 10'h3FF, 7'h7F));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrKeyinHi,
                            8'hFF, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrExtkeyLo,
                            8'h00, 10'h000, 7'h7F));
    // extra key high byte reads 0 whatever the lines
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrExtkeyHi,
                            8'hFF, 10'h3FF, 7'h7F));
  endtask

  // key interrupt control per port, high byte masked
  task automatic test_key_control();
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, dcsio_pkg::AddrKeyctlLo,
                            8'hFF, 10'h155, 7'h2A));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, dcsio_pkg::AddrKeyctlHi,
                            8'hFF, 10'h2AA, 7'h55));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, dcsio_pkg::AddrKeyctlHi,
                            8'h00, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuSecond, dcsio_pkg::AddrKeyctlHi,
                            8'hFF, 10'h3FF, 7'h7F));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrKeyctlLo,
                            8'h00, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrKeyctlHi,
                            8'h00, 10'h000, 7'h00));
  endtask

  // memory control with its forced bit and the status mirror
  task automatic test_memory_control();
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, dcsio_pkg::AddrMemHi,
                            8'h00, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, dcsio_pkg::AddrMemLo,
                            8'hFF, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, dcsio_pkg::AddrMemHi,
                            8'h00, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrMemHi,
                            8'h00, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuSecond, dcsio_pkg::AddrMemLo,
                            8'hFF, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuSecond, dcsio_pkg::AddrMemHi,
                            8'hFF, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrMemLo,
                            8'h00, 10'h000, 7'h00));
  endtask

  // mapping field: reset value on the main port, write with refresh, read back on the secondary port
  task automatic test_wram_map();
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, dcsio_pkg::AddrWmapMain,
                            8'h00, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, dcsio_pkg::AddrWmapMain,
                            8'hFC, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuSecond, dcsio_pkg::AddrWmapSec,
                            8'h00, 10'h000, 7'h00));
    // read-only through the secondary port
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuSecond, dcsio_pkg::AddrWmapSec,
                            8'hFF, 10'h000, 7'h00));
  endtask

  // unmapped addresses and writes to read-only registers
  task automatic test_unknown_addresses();
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, 32'hFFFF_FFFF,
                            8'h00, 10'h3FF, 7'h7F));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, 32'h0000_0000,
                            8'hFF, 10'h000, 7'h00));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuMain, dcsio_pkg::AddrKeyinLo,
                            8'hFF, 10'h3FF, 7'h7F));
    send_access(make_access(dcsio_pkg::ModeRead, dcsio_pkg::CpuMain, dcsio_pkg::AddrExtkeyLo,
                            8'h00, 10'h000, 7'h7F));
    send_access(make_access(dcsio_pkg::ModeWrite, dcsio_pkg::CpuSecond, dcsio_pkg::AddrExtkeyLo,
                            8'hFF, 10'h000, 7'h7F));
  endtask

  function automatic dcsio_pkg::access_t random_access();
    dcsio_pkg::access_t acc;
    int unsigned        pick;
    acc.mode       = 1'($urandom_range(0, 1));
    acc.cpu        = 1'($urandom_range(0, 1));
    acc.write_data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    // mostly real registers, some near misses, some anywhere in the space
    if (pick < 16)      acc.address = reg_addrs[4'($urandom_range(0, 9))];
    else if (pick < 18) acc.address = 32'h0400_0100 + 32'($urandom_range(0, 'h180));
    else                acc.address = $urandom;
    pick = $urandom_range(0, 7);
    if (pick == 0)      acc.key_lines = '0;
    else if (pick == 1) acc.key_lines = '1;
    else                acc.key_lines = 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 7);
    if (pick == 0)      acc.ext_key_lines = '0;
    else if (pick == 1) acc.ext_key_lines = '1;
    else                acc.ext_key_lines = 7'($urandom_range(0, 127));
    return acc;
  endfunction

  // receiver stops for a long stretch while transactions keep coming,
  // so the pipeline fills and in_ready has to drop
  task automatic test_backpressure();
    rx_hold_cycles = 80;
    tx_quiet       = 1'b1;
    tx_run_left    = 30;
    repeat (30) send_access(random_access());
  endtask

  task automatic test_random_traffic();
    repeat (RandomCount) send_access(random_access());
  endtask

  initial begin
    // every input known from time zero, reset held low at the start
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    mode          <= dcsio_pkg::ModeRead;
    cpu           <= dcsio_pkg::CpuMain;
    address       <= '0;
    write_data    <= '0;
    key_lines     <= '1;
    ext_key_lines <= '1;
    sh_key_ctrl_main   = '0;
    sh_key_ctrl_second = '0;
    sh_mem_ctrl        = '0;
    sh_mem_status      = '0;
    sh_wram_map        = dcsio_pkg::WmapReset;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_key_inputs();
    test_key_control();
    test_memory_control();
    test_wram_map();
    test_unknown_addresses();
    test_backpressure();
    test_random_traffic();

    // drop valid once, let the owed replies drain, then watch for strays
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
